// File: rtl/lpfl_pkg.sv
// lpfl_pkg: shared constants, codes and state type of the layered pool free list
`default_nettype none

package lpfl_pkg;

	localparam int POOL_SIZE_DEF   = 128;
	localparam int LAYER_COUNT_DEF = 8;

	localparam int FUNC_W   = 2;
	localparam int LAYER_W  = 3;
	localparam int ENTRY_W  = 7;
	localparam int COUNT_W  = 8;
	localparam int STATUS_W = 2;

	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 16;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ALLOC,
		FUNC_FREE,
		FUNC_CLEAR_LAYER,
		FUNC_CLEAR_ALL
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK,
		STATUS_EMPTY,
		STATUS_BAD_LAYER,
		STATUS_NOT_IN_USE
	} status_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_A1,
		ST_A2,
		ST_A3,
		ST_A4,
		ST_F1,
		ST_F2,
		ST_F3,
		ST_C1,
		ST_C2,
		ST_C3,
		ST_C4,
		ST_C5,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// File: rtl/lpfl_ram.sv
// lpfl_ram: generic single write port, single read port ram with registered read
`default_nettype none

module lpfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/layered_pool_free_list.sv
// layered_pool_free_list: pool allocator with a free ring and per-layer rings in link rams
// a bad layer goes straight to the result; an empty pool or an unused entry ends the item early;
// clear all reruns the init pass over all NODE_COUNT nodes, NODE_COUNT = POOL_SIZE + 1 + LAYER_COUNT
// one item at a time; a new item is taken once the result is in the output register
// after reset a pass over every node builds the free ring; no item is taken meanwhile
`default_nettype none

module layered_pool_free_list import lpfl_pkg::*; #(
	parameter int POOL_SIZE   = POOL_SIZE_DEF,
	parameter int LAYER_COUNT = LAYER_COUNT_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,  // layer[2:0], entry[9:3], zero pad
	input  wire logic [FUNC_W-1:0]   s_tuser,  // func[1:0]
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic      [M_DATA_W-1:0] m_tdata,  // entry_out[6:0], freed_count[14:7], zero pad
	output logic      [STATUS_W-1:0] m_tuser   // status[1:0]
);

	localparam int NODE_COUNT = POOL_SIZE + 1 + LAYER_COUNT;
	localparam int LW = $clog2(NODE_COUNT);
	localparam int CW = $clog2(POOL_SIZE + 1);
	localparam logic [LW-1:0] FREE_SENT  = LW'(POOL_SIZE);
	localparam logic [LW-1:0] LAYER_BASE = LW'(POOL_SIZE + 1);
	localparam logic [LW-1:0] LAST_NODE  = LW'(NODE_COUNT - 1);
	localparam logic [LW-1:0] LAST_ENTRY = LW'(POOL_SIZE - 1);
	localparam logic [CW-1:0] GUARD_LIM  = CW'(POOL_SIZE);

	state_t state_q, state_d;

	logic [LAYER_W-1:0] in_layer;
	logic [ENTRY_W-1:0] in_entry;
	func_t              in_func;
	logic [LW-1:0]      in_lsent;
	logic [LW-1:0]      in_enode;
	logic               in_bad_layer;
	logic               in_acc;

	logic          n_we, p_we;
	logic [LW-1:0] n_waddr, n_raddr, p_waddr, p_raddr;
	logic [LW:0]   n_wdata, n_rdata;
	logic [LW-1:0] p_wdata, p_rdata;
	logic [LW-1:0] nrd_link;
	logic          nrd_used;

	logic [LW-1:0] ini_q;
	logic          init_op_q;
	logic [LW:0]   ini_next;
	logic [LW-1:0] ini_prev;

	logic [LW-1:0] s_q, e_q, n_q, t_q, p_q, nx_q;
	logic [CW-1:0] cnt_q;
	logic          c_stop;
	logic          out_free;

	logic [ENTRY_W-1:0] res_entry_q, out_entry_q;
	logic [COUNT_W-1:0] res_count_q, out_count_q;
	status_t            res_status_q, out_status_q;
	logic               out_valid_q;

	assign in_layer     = s_tdata[LAYER_W-1:0];
	assign in_entry     = s_tdata[LAYER_W+ENTRY_W-1:LAYER_W];
	assign in_func      = func_t'(s_tuser);
	assign in_lsent     = LAYER_BASE + LW'(in_layer);
	assign in_enode     = LW'(in_entry);
	assign in_bad_layer = 32'(in_layer) >= 32'(LAYER_COUNT);
	assign s_tready     = (state_q == ST_IDLE);
	assign in_acc       = s_tvalid && s_tready;

	assign nrd_link = n_rdata[LW-1:0];
	assign nrd_used = n_rdata[LW];
	assign c_stop   = (p_q == s_q) || (p_q >= FREE_SENT) || (cnt_q >= GUARD_LIM);
	assign out_free = !out_valid_q || m_tready;

	// free ring in index order, every layer ring closed on its sentinel
	always_comb begin
		if (ini_q < FREE_SENT) begin
			ini_next = {1'b0, (ini_q == LAST_ENTRY) ? FREE_SENT : ini_q + LW'(1)};
			ini_prev = (ini_q == '0) ? FREE_SENT : ini_q - LW'(1);
		end else if (ini_q == FREE_SENT) begin
			ini_next = '0;
			ini_prev = LAST_ENTRY;
		end else begin
			ini_next = {1'b0, ini_q};
			ini_prev = ini_q;
		end
	end

	lpfl_ram #(
		.WIDTH(LW + 1),
		.DEPTH(NODE_COUNT)
	) u_next_ram (
		.clk  (clk),
		.we   (n_we),
		.waddr(n_waddr),
		.wdata(n_wdata),
		.raddr(n_raddr),
		.rdata(n_rdata)
	);

	lpfl_ram #(
		.WIDTH(LW),
		.DEPTH(NODE_COUNT)
	) u_prev_ram (
		.clk  (clk),
		.we   (p_we),
		.waddr(p_waddr),
		.wdata(p_wdata),
		.raddr(p_raddr),
		.rdata(p_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (ini_q == LAST_NODE) begin
					state_d = init_op_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_acc) begin
					case (in_func)
						FUNC_ALLOC:       state_d = in_bad_layer ? ST_DONE : ST_A1;
						FUNC_FREE:        state_d = (in_enode >= FREE_SENT) ? ST_DONE : ST_F1;
						FUNC_CLEAR_LAYER: state_d = in_bad_layer ? ST_DONE : ST_C1;
						FUNC_CLEAR_ALL:   state_d = ST_INIT;
						default:          state_d = ST_IDLE;
					endcase
				end
			end
			ST_A1:   state_d = (nrd_link >= FREE_SENT) ? ST_DONE : ST_A2;
			ST_A2:   state_d = ST_A3;
			ST_A3:   state_d = ST_A4;
			ST_A4:   state_d = ST_DONE;
			ST_F1:   state_d = nrd_used ? ST_F2 : ST_DONE;
			ST_F2:   state_d = ST_F3;
			ST_F3:   state_d = ST_DONE;
			ST_C1:   state_d = ST_C2;
			ST_C2:   state_d = c_stop ? ST_DONE : ST_C3;
			ST_C3:   state_d = ST_C4;
			ST_C4:   state_d = ST_C5;
			ST_C5:   state_d = ST_C2;
			ST_DONE: state_d = out_free ? ST_IDLE : ST_DONE;
			default: state_d = ST_INIT;
		endcase
	end

	always_comb begin
		n_we    = 1'b0;
		n_waddr = '0;
		n_wdata = '0;
		n_raddr = '0;
		p_we    = 1'b0;
		p_waddr = '0;
		p_wdata = '0;
		p_raddr = '0;
		case (state_q)
			ST_INIT: begin
				n_we    = 1'b1;
				n_waddr = ini_q;
				n_wdata = ini_next;
				p_we    = 1'b1;
				p_waddr = ini_q;
				p_wdata = ini_prev;
			end
			ST_IDLE: begin
				case (in_func)
					FUNC_ALLOC: begin
						n_raddr = FREE_SENT;
						p_raddr = in_lsent;
					end
					FUNC_FREE: begin
						n_raddr = in_enode;
						p_raddr = in_enode;
					end
					FUNC_CLEAR_LAYER: n_raddr = in_lsent;
					default: n_raddr = '0;
				endcase
			end
			ST_A1: begin
				n_raddr = nrd_link;
				p_raddr = nrd_link;
			end
			// unlink the old free head
			ST_A2: begin
				p_we    = 1'b1;
				p_waddr = nrd_link;
				p_wdata = p_rdata;
				n_we    = 1'b1;
				n_waddr = p_rdata;
				n_wdata = {1'b0, nrd_link};
			end
			ST_A3: begin
				n_we    = 1'b1;
				n_waddr = t_q;
				n_wdata = {(t_q < FREE_SENT), n_q};
				p_we    = 1'b1;
				p_waddr = n_q;
				p_wdata = t_q;
			end
			ST_A4: begin
				p_we    = 1'b1;
				p_waddr = s_q;
				p_wdata = n_q;
				n_we    = 1'b1;
				n_waddr = n_q;
				n_wdata = {1'b1, s_q};
			end
			ST_F1: begin
				n_raddr = FREE_SENT;
				if (nrd_used) begin
					p_we    = 1'b1;
					p_waddr = nrd_link;
					p_wdata = p_rdata;
					n_we    = 1'b1;
					n_waddr = p_rdata;
					n_wdata = {(p_rdata < FREE_SENT), nrd_link};
				end
			end
			ST_F2: begin
				p_we    = 1'b1;
				p_waddr = nrd_link;
				p_wdata = e_q;
				n_we    = 1'b1;
				n_waddr = e_q;
				n_wdata = {1'b0, nrd_link};
			end
			ST_F3: begin
				p_we    = 1'b1;
				p_waddr = e_q;
				p_wdata = FREE_SENT;
				n_we    = 1'b1;
				n_waddr = FREE_SENT;
				n_wdata = {1'b0, e_q};
			end
			ST_C2: begin
				n_raddr = p_q;
				p_raddr = p_q;
			end
			ST_C3: begin
				n_raddr = FREE_SENT;
				p_we    = 1'b1;
				p_waddr = nrd_link;
				p_wdata = p_rdata;
				n_we    = 1'b1;
				n_waddr = p_rdata;
				n_wdata = {(p_rdata < FREE_SENT), nrd_link};
			end
			ST_C4: begin
				p_we    = 1'b1;
				p_waddr = nrd_link;
				p_wdata = p_q;
				n_we    = 1'b1;
				n_waddr = p_q;
				n_wdata = {1'b0, nrd_link};
			end
			ST_C5: begin
				p_we    = 1'b1;
				p_waddr = p_q;
				p_wdata = FREE_SENT;
				n_we    = 1'b1;
				n_waddr = FREE_SENT;
				n_wdata = {1'b0, p_q};
			end
			default: n_raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			ini_q       <= '0;
			init_op_q   <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT) begin
				ini_q <= ini_q + LW'(1);
			end else if (in_acc) begin
				ini_q <= '0;
			end
			if (in_acc) begin
				init_op_q <= (in_func == FUNC_CLEAR_ALL);
			end
			if (state_q == ST_C1) begin
				cnt_q <= '0;
			end else if (state_q == ST_C5) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s_q         <= in_lsent;
			e_q         <= in_enode;
			res_entry_q <= (in_func == FUNC_FREE) ? in_entry : '0;
			res_count_q <= '0;
			case (in_func)
				FUNC_ALLOC, FUNC_CLEAR_LAYER: begin
					res_status_q <= in_bad_layer ? STATUS_BAD_LAYER : STATUS_OK;
				end
				FUNC_FREE: begin
					res_status_q <= (in_enode >= FREE_SENT) ? STATUS_NOT_IN_USE : STATUS_OK;
				end
				default: res_status_q <= STATUS_OK;
			endcase
		end
		case (state_q)
			ST_A1: begin
				n_q <= nrd_link;
				t_q <= p_rdata;
				if (nrd_link >= FREE_SENT) begin
					res_status_q <= STATUS_EMPTY;
				end
			end
			ST_A4: res_entry_q <= ENTRY_W'(n_q);
			ST_F1: begin
				if (!nrd_used) begin
					res_status_q <= STATUS_NOT_IN_USE;
				end
			end
			ST_C1: p_q <= nrd_link;
			ST_C2: res_count_q <= COUNT_W'(cnt_q);
			ST_C3: nx_q <= nrd_link;
			ST_C5: p_q <= nx_q;
			default: ;
		endcase
		if (state_q == ST_DONE && out_free) begin
			out_entry_q  <= res_entry_q;
			out_count_q  <= res_count_q;
			out_status_q <= res_status_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_DATA_W'({out_count_q, out_entry_q});
	assign m_tuser  = out_status_q;

	// a clear never walks more entries than the pool holds
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= GUARD_LIM)
		else $error("clear layer walk count beyond pool size");

	// link writes stay inside the node range
	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(n_we || p_we) |-> (n_waddr <= LAST_NODE && p_waddr <= LAST_NODE))
		else $error("link write outside node range");

	// only a successful clear layer reports a freed count
	a_count_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != STATUS_OK) |-> (m_tdata[ENTRY_W+COUNT_W-1:ENTRY_W] == '0))
		else $error("freed count on a rejected item");

	// an item is taken only when the init pass has finished
	a_no_accept_init: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT && ini_q != LAST_NODE) |=> !(s_tvalid && s_tready))
		else $error("item taken during ring rebuild");

endmodule

`default_nettype wire
